// File: rtl/euler_to_basis_vectors_unit_assert.svh
// Assertion macros for the euler_to_basis_vectors_unit RTL.
// Depends on nothing; included by files that assert.
`ifndef EULER_TO_BASIS_VECTORS_UNIT_ASSERT_SVH
`define EULER_TO_BASIS_VECTORS_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define E2B_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define E2B_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: rtl/e2b_pkg.sv
// Package for the Euler-angle to basis-vector unit.
// Holds the CORDIC arctangent table and fixed constants; no dependencies.
package e2b_pkg;
  localparam int QW = 32;           // Q30 datapath width incl. headroom
  localparam int OUT_W = 16;
  localparam int IN_W = 17;
  localparam logic signed [QW-1:0] CORDIC_GAIN = 32'sd652032874;

  function automatic logic signed [QW+1:0] atan_val(input int i);
    logic signed [QW+1:0] t [0:31];
    t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
          34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
          34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
          34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215,
          34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81,
          34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1, 34'sd1, 34'sd0};
    return t[i];
  endfunction

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW+1:0] z;
    logic                 flip;
  } cordic_t;
endpackage

// File: rtl/e2b_cell.sv
// One CORDIC rotation cell: rotates one angle by atan(2^-STAGE).
// Depends on e2b_pkg.
module e2b_cell import e2b_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  cordic_t din,
  output cordic_t dout
);
  cordic_t nxt;
  always_comb begin
    nxt = din;
    if (!din.z[QW+1]) begin
      nxt.x = din.x - (din.y >>> STAGE);
      nxt.y = din.y + (din.x >>> STAGE);
      nxt.z = din.z - atan_val(STAGE);
    end else begin
      nxt.x = din.x + (din.y >>> STAGE);
      nxt.y = din.y - (din.x >>> STAGE);
      nxt.z = din.z + atan_val(STAGE);
    end
  end
  always_ff @(posedge clk) begin
    dout <= nxt;
  end
endmodule

// File: rtl/e2b_prep.sv
// Angle reduction: degrees to a binary angle folded into +-90 deg.
// Depends on e2b_pkg. Two registered stages.
module e2b_prep import e2b_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                   clk,
  input  logic signed [IN_W-1:0] ang,
  output cordic_t                dout
);
  localparam int TURN = 360 << ANGLE_FRAC_BITS;
  // whole turns added so that any 17-bit input becomes non-negative
  localparam int OFF = TURN * (((1 << (IN_W-1)) + TURN - 1) / TURN);
  localparam int VW = $clog2(OFF + (1 << (IN_W-1)));
  localparam int SH = VW + 6;
  localparam longint RECIP = ((64'sd1 <<< SH) + 44) / 45;
  localparam int UW = VW - 5;
  localparam int FS = 29 - ANGLE_FRAC_BITS;

  // binary angle of a remainder r in 0..44: round(r * 2^FS / 45)
  function automatic logic [45*32-1:0] frac_tab();
    logic [45*32-1:0] t;
    longint v;
    t = '0;
    for (int r = 0; r < 45; r++) begin
      v = ((longint'(r) <<< FS) + 22) / 45;
      t[r*32 +: 32] = v[31:0];
    end
    return t;
  endfunction

  localparam logic [45*32-1:0] FRAC_TAB = frac_tab();

  logic [VW-1:0] vp;
  logic [2*VW+1:0] prod;
  logic [UW-1:0] u;
  logic [UW-1:0] u_q;
  logic [VW-1:0] rem;
  logic [5:0] r_q;
  logic [63:0] ub;
  logic [31:0] ba;
  logic signed [QW+1:0] z;
  logic flip;

  // binary angle = u * 2^FS + round(r * 2^FS / 45) with vp = 45 * u + r;
  // the added whole turns vanish in the 32-bit wrap
  always_comb begin
    vp = VW'((VW+1)'(ang) + (VW+1)'(OFF));
    prod = (2*VW+2)'(vp) * (2*VW+2)'(RECIP);
    u = prod[SH +: UW];
    rem = vp - VW'(u) * VW'(45);
  end
  always_ff @(posedge clk) begin
    u_q <= u;
    r_q <= rem[5:0];
  end

  always_comb begin
    ub = 64'(u_q) << FS;
    ba = ub[31:0] + FRAC_TAB[32*r_q +: 32];
    z = (QW+2)'($signed(ba));
    flip = 1'b0;
    if (z > (QW+2)'(34'sd1 <<< 30)) begin
      z = z - (34'sd1 <<< 31); flip = 1'b1;
    end else if (z < -(34'sd1 <<< 30)) begin
      z = z + (34'sd1 <<< 31); flip = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    dout.x <= CORDIC_GAIN;
    dout.y <= '0;
    dout.z <= z;
    dout.flip <= flip;
  end
endmodule

// File: rtl/e2b_combine.sv
// Product network: sines and cosines to nine saturated Q components.
// Depends on e2b_pkg. Three registered stages.
module e2b_combine import e2b_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic signed [QW-1:0]    sp, cp, sy, cy, sr, cr,
  output logic signed [OUT_W-1:0] o [9]
);
  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return QW'(p >>> 30);
  endfunction
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] r;
    logic signed [QW+1:0] lim;
    lim = (QW+2)'(1) <<< OUT_FRAC_BITS;
    if (OUT_FRAC_BITS < 30)
      r = (v + ((QW+2)'(1) <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
    else
      r = v;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return OUT_W'(r);
  endfunction

  logic signed [QW-1:0] srsp, crsp, p_cpcy, p_cpsy, p_nsp, p_sry, p_srcy, p_crsy;
  logic signed [QW-1:0] p_crcy, p_srcp, p_crcp, s_cy, s_sy, s_cr, s_sr;
  logic signed [QW-1:0] a0, a1, a2, a3;
  always_ff @(posedge clk) begin
    srsp <= qmul(sr, sp);
    crsp <= qmul(cr, sp);
    p_cpcy <= qmul(cp, cy);
    p_cpsy <= qmul(cp, sy);
    p_nsp <= -sp;
    p_sry <= qmul(sr, sy);
    p_srcy <= qmul(sr, cy);
    p_crsy <= qmul(cr, sy);
    p_crcy <= qmul(cr, cy);
    p_srcp <= qmul(sr, cp);
    p_crcp <= qmul(cr, cp);
    s_cy <= cy;
    s_sy <= sy;
    a0 <= qmul(srsp, s_cy);
    a1 <= qmul(srsp, s_sy);
    a2 <= qmul(crsp, s_cy);
    a3 <= qmul(crsp, s_sy);
    s_cr <= p_crsy;
    s_sr <= p_crcy;
  end
  logic signed [QW-1:0] d_cpcy, d_cpsy, d_nsp, d_sry, d_srcy, d_srcp, d_crcp;
  always_ff @(posedge clk) begin
    d_cpcy <= p_cpcy; d_cpsy <= p_cpsy; d_nsp <= p_nsp; d_sry <= p_sry;
    d_srcy <= p_srcy; d_srcp <= p_srcp; d_crcp <= p_crcp;
    o[0] <= to_out((QW+2)'(d_cpcy));
    o[1] <= to_out((QW+2)'(d_cpsy));
    o[2] <= to_out((QW+2)'(d_nsp));
    o[3] <= to_out(-(QW+2)'(a0) + (QW+2)'(s_cr));
    o[4] <= to_out(-(QW+2)'(a1) - (QW+2)'(s_sr));
    o[5] <= to_out(-(QW+2)'(d_srcp));
    o[6] <= to_out((QW+2)'(a2) + (QW+2)'(d_sry));
    o[7] <= to_out((QW+2)'(a3) - (QW+2)'(d_srcy));
    o[8] <= to_out((QW+2)'(d_crcp));
  end
endmodule

// File: rtl/euler_to_basis_vectors_unit.sv
// Euler angles (pitch, yaw, roll) to forward, right and up basis vectors.
// One command beat in: pulse start with pitch_deg, yaw_deg, roll_deg while
// busy is low. busy is tied low: a new beat may follow every cycle.
// Each angle passes a two-stage reduction (wrap to one turn, convert to a
// binary angle by reciprocal multiply, fold into +-90 deg), then a chain of
// CORDIC_STAGES rotation cells, one register each, three chains in parallel.
// A three-stage product network forms the nine Q1.14 saturated components.
// Start to done: prep stages, cell chain, fold-undo register, product stages;
// throughput one beat per cycle, set by the fully pipelined cell chain.
// done is high for exactly one cycle with the nine result ports; the
// receiver cannot stall, so results are never held.
// Reset clears the valid shift line only; data registers carry no reset.
// Uses e2b_pkg, e2b_prep, e2b_cell and e2b_combine.
`include "euler_to_basis_vectors_unit_assert.svh"
module euler_to_basis_vectors_unit import e2b_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int OUT_FRAC_BITS   = 14,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  pitch_deg,
  input  logic signed [IN_W-1:0]  yaw_deg,
  input  logic signed [IN_W-1:0]  roll_deg,
  output logic                    done,
  output logic signed [OUT_W-1:0] fwd_x, fwd_y, fwd_z,
  output logic signed [OUT_W-1:0] right_x, right_y, right_z,
  output logic signed [OUT_W-1:0] up_x, up_y, up_z
);
  localparam int LAT = CORDIC_STAGES + 6;
  logic [LAT-1:0] vld;
  logic signed [IN_W-1:0] ang [3];
  cordic_t chain [3][CORDIC_STAGES+1];
  logic signed [QW-1:0] s [3];
  logic signed [QW-1:0] c [3];
  logic signed [OUT_W-1:0] o [9];

  assign busy = 1'b0;
  assign ang[0] = pitch_deg;
  assign ang[1] = yaw_deg;
  assign ang[2] = roll_deg;

  // advance the valid marks alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign done = vld[LAT-1];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    e2b_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep (
      .clk(clk), .ang(ang[a]), .dout(chain[a][0]));
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      e2b_cell #(.STAGE(k)) u_cell (
        .clk(clk), .din(chain[a][k]), .dout(chain[a][k+1]));
    end
    // undo the half-turn fold
    always_ff @(posedge clk) begin
      s[a] <= chain[a][CORDIC_STAGES].flip ? -chain[a][CORDIC_STAGES].y
                                          : chain[a][CORDIC_STAGES].y;
      c[a] <= chain[a][CORDIC_STAGES].flip ? -chain[a][CORDIC_STAGES].x
                                          : chain[a][CORDIC_STAGES].x;
    end
  end

  e2b_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
    .clk(clk), .sp(s[0]), .cp(c[0]), .sy(s[1]), .cy(c[1]), .sr(s[2]), .cr(c[2]),
    .o(o));

  assign fwd_x = o[0];
  assign fwd_y = o[1];
  assign fwd_z = o[2];
  assign right_x = o[3];
  assign right_y = o[4];
  assign right_z = o[5];
  assign up_x = o[6];
  assign up_y = o[7];
  assign up_z = o[8];

  `E2B_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy)
  `E2B_ASSERT_NXT(a_start_tracked, clk, rst, start, vld[0])
  `E2B_ASSERT_IMP(a_done_sat, clk, rst, done,
    (up_z <= (OUT_W'(1) <<< OUT_FRAC_BITS)) && (up_z >= -(OUT_W'(1) <<< OUT_FRAC_BITS)))
endmodule
